FILE: sv/mst_pkg.sv
// ----------------------------------------------------------------------------
// mst_pkg
// shared types and constants of the perceptron trainer: opcodes, datapath
// commands and fixed-point widths
// ----------------------------------------------------------------------------
package mst_pkg;

    localparam int DATA_W = 16;        // stored weights and features, q4.12
    localparam int ACT_W  = 13;        // sigmoid outputs and targets
    localparam int LR_W   = 13;
    localparam int ADDR_W = 9;         // enough for the largest network
    localparam int IDX_W  = 5;         // neuron and term counters
    localparam int ACC_W  = 40;
    localparam int OPB_W  = 20;
    localparam int MULA_W = 33;
    localparam int PROD_W = 53;
    localparam int DRV_W  = 11;        // sigmoid derivative, at most 1024
    localparam int DH_W   = 20;        // hidden delta
    localparam int Q_ONE  = 4096;

    localparam logic [LR_W-1:0] LR_RESET = 13'd410;
    localparam logic REG_LEARNING_RATE = 1'b0;

    typedef enum logic [1:0] {
        OPC_WRITE   = 2'd0,
        OPC_READ    = 2'd1,
        OPC_FORWARD = 2'd2,
        OPC_TRAIN   = 2'd3
    } opcode_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_WRITE,
        DP_READ,
        DP_MUL,
        DP_ACC,
        DP_ACT,
        DP_DER_O,
        DP_DEL_O,
        DP_DER_H,
        DP_DEL_H,
        DP_LD,
        DP_UPD,
        DP_PUB
    } dp_op_t;

    typedef enum logic [1:0] {
        OPD_FEAT,
        OPD_ONE,
        OPD_HID,
        OPD_DOUT
    } opd_t;

    typedef enum logic [1:0] {
        PUB_ZERO,
        PUB_OUT,
        PUB_RB
    } pub_t;

    typedef struct packed {
        dp_op_t             op;
        logic [ADDR_W-1:0]  addr;
        logic [IDX_W-1:0]   nidx;    // neuron
        logic [IDX_W-1:0]   tidx;    // term within a neuron
        logic               layer;   // 1: output layer
        opd_t               opd;
        logic               use_ld;
        logic               first;
        pub_t               pub;
    } dp_cmd_t;

endpackage

FILE: sv/mlp_sigmoid_sgd_trainer_core.sv
// ----------------------------------------------------------------------------
// mlp_sigmoid_sgd_trainer_core
// trainable sigmoid perceptron with one hidden layer, q4.12, one sgd step
// per train item
// ----------------------------------------------------------------------------
// throughput: one item at a time, set by the single-port weight memory and
//   the shared multiplier
// reset: control state and learning rate (410) clear asynchronously, the
//   weight memory holds nothing defined until written
module mlp_sigmoid_sgd_trainer_core
    import mst_pkg::*;
#(
    parameter int INPUT_COUNT        = 3,
    parameter int HIDDEN_COUNT       = 5,
    parameter int OUTPUT_COUNT       = 3,
    parameter int SIGMOID_TABLE_SIZE = 256
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // item channel
    input  logic                     item_valid,
    output logic                     item_ready,
    input  logic [1:0]               opcode,
    input  logic signed [DATA_W-1:0] feature_0,
    input  logic signed [DATA_W-1:0] feature_1,
    input  logic signed [DATA_W-1:0] feature_2,
    input  logic [ACT_W-1:0]         target_0,
    input  logic [ACT_W-1:0]         target_1,
    input  logic [ACT_W-1:0]         target_2,
    input  logic [5:0]               weight_index,
    input  logic signed [DATA_W-1:0] weight_value,
    // result channel
    output logic                     result_valid,
    input  logic                     result_ready,
    output logic [ACT_W-1:0]         out_0,
    output logic [ACT_W-1:0]         out_1,
    output logic [ACT_W-1:0]         out_2,
    output logic signed [DATA_W-1:0] weight_readback,
    // register port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    // learning rate register, the only register, at byte address 0
    logic [LR_W-1:0] lr_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LEARNING_RATE) ? {{(32 - LR_W){1'b0}}, lr_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg <= LR_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_LEARNING_RATE)
        begin
            lr_reg <= pwdata[LR_W-1:0];
        end
    end

    // controller and datapath meet only through the command word and load
    dp_cmd_t cmd;
    logic    load;

    mst_ctrl #(
        .INPUT_COUNT  (INPUT_COUNT),
        .HIDDEN_COUNT (HIDDEN_COUNT),
        .OUTPUT_COUNT (OUTPUT_COUNT)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .opcode       (opcode),
        .weight_index (weight_index),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cmd          (cmd),
        .load         (load)
    );

    // weights, shared multiply-accumulate, sigmoid table, result registers
    mst_dp #(
        .INPUT_COUNT        (INPUT_COUNT),
        .HIDDEN_COUNT       (HIDDEN_COUNT),
        .OUTPUT_COUNT       (OUTPUT_COUNT),
        .SIGMOID_TABLE_SIZE (SIGMOID_TABLE_SIZE)
    ) u_dp (
        .clk             (clk),
        .cmd             (cmd),
        .load            (load),
        .feature_0       (feature_0),
        .feature_1       (feature_1),
        .feature_2       (feature_2),
        .target_0        (target_0),
        .target_1        (target_1),
        .target_2        (target_2),
        .weight_value    (weight_value),
        .lr              (lr_reg),
        .out_0           (out_0),
        .out_1           (out_1),
        .out_2           (out_2),
        .weight_readback (weight_readback)
    );

endmodule

FILE: sv/mst_dp.sv
// ----------------------------------------------------------------------------
// mst_dp
// datapath: weight memory, shared multiply-accumulate unit, sigmoid table,
// delta and update arithmetic, result registers
// ----------------------------------------------------------------------------
module mst_dp
    import mst_pkg::*;
#(
    parameter int INPUT_COUNT        = 3,
    parameter int HIDDEN_COUNT       = 5,
    parameter int OUTPUT_COUNT       = 3,
    parameter int SIGMOID_TABLE_SIZE = 256
)
(
    input  logic                     clk,
    input  dp_cmd_t                  cmd,
    input  logic                     load,
    input  logic signed [DATA_W-1:0] feature_0,
    input  logic signed [DATA_W-1:0] feature_1,
    input  logic signed [DATA_W-1:0] feature_2,
    input  logic [ACT_W-1:0]         target_0,
    input  logic [ACT_W-1:0]         target_1,
    input  logic [ACT_W-1:0]         target_2,
    input  logic signed [DATA_W-1:0] weight_value,
    input  logic [LR_W-1:0]          lr,
    output logic [ACT_W-1:0]         out_0,
    output logic [ACT_W-1:0]         out_1,
    output logic [ACT_W-1:0]         out_2,
    output logic signed [DATA_W-1:0] weight_readback
);

    localparam int WEIGHT_COUNT = HIDDEN_COUNT * INPUT_COUNT + HIDDEN_COUNT
                                + OUTPUT_COUNT * HIDDEN_COUNT + OUTPUT_COUNT;
    localparam int MEM_AW = $clog2(WEIGHT_COUNT);
    localparam int TBL_AW = $clog2(SIGMOID_TABLE_SIZE);
    localparam int IN_IW  = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;
    localparam int HID_IW = (HIDDEN_COUNT > 1) ? $clog2(HIDDEN_COUNT) : 1;
    localparam int OUT_IW = (OUTPUT_COUNT > 1) ? $clog2(OUTPUT_COUNT) : 1;
    localparam longint unsigned Q30 = 64'd1 << 30;

    typedef logic [ACT_W-1:0] tbl_t [SIGMOID_TABLE_SIZE];

    // restoring long division, used only while the table is elaborated
    function automatic longint unsigned udiv(input longint unsigned a,
                                             input longint unsigned b);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[62:0], a[i]};
            if (r >= b)
            begin
                r    = r - b;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // round(4096 * sigmoid) at the middle of each cell, approximate integer exp
    function automatic tbl_t build_table();
        tbl_t             tb;
        longint           d;
        longint unsigned  n, a, t, t2, t3, e, num, den;
        for (int k = 0; k < SIGMOID_TABLE_SIZE; k++)
        begin
            d = 32 * longint'(k) + 16 - 16 * longint'(SIGMOID_TABLE_SIZE);
            n = (d < 0) ? longint'(-d) : longint'(d);
            a = udiv(n << 30, 64'(2 * SIGMOID_TABLE_SIZE));
            t = a >> 8;
            t2 = (t * t) >> 30;
            t3 = (t2 * t) >> 30;
            e = Q30 - t + (t2 >> 1) - udiv(t3, 64'd6);
            for (int r = 0; r < 8; r++)
            begin
                e = (e * e) >> 30;
            end
            den = Q30 + e;
            num = (d < 0) ? e : Q30;
            tb[k] = ACT_W'(udiv(64'd4096 * num + (den >> 1), den));
        end
        return tb;
    endfunction

    localparam tbl_t SIG_TBL = build_table();

    function automatic logic [DRV_W-1:0] deriv(input logic [ACT_W-1:0] y);
        logic [25:0] p;
        p = 26'(y) * 26'(ACT_W'(Q_ONE) - y);
        return p[12 +: DRV_W];
    endfunction

    logic signed [DATA_W-1:0] mem [WEIGHT_COUNT];
    logic signed [DATA_W-1:0] rdata_reg;
    logic signed [DATA_W-1:0] feat_reg [INPUT_COUNT];
    logic [ACT_W-1:0]         tgt_reg [OUTPUT_COUNT];
    logic signed [DATA_W-1:0] wv_reg;
    logic [ACT_W-1:0]         hid_reg [HIDDEN_COUNT];
    logic [ACT_W-1:0]         outv_reg [OUTPUT_COUNT];
    logic signed [DATA_W-1:0] dout_reg [OUTPUT_COUNT];
    logic signed [DH_W-1:0]   dhid_reg [HIDDEN_COUNT];
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [14:0]       diff_reg;
    logic [DRV_W-1:0]         drv_reg;
    logic signed [DH_W-1:0]   gq_reg;
    logic signed [MULA_W-1:0] ld_reg;

    logic signed [DATA_W-1:0] feat_in [INPUT_COUNT];
    logic [ACT_W-1:0]         tgt_in [OUTPUT_COUNT];
    logic [ACT_W-1:0]         outs_w [3];
    logic signed [DATA_W-1:0] feat_port [3];
    logic [ACT_W-1:0]         tgt_port [3];

    assign feat_port[0] = feature_0;
    assign feat_port[1] = feature_1;
    assign feat_port[2] = feature_2;
    assign tgt_port[0]  = target_0;
    assign tgt_port[1]  = target_1;
    assign tgt_port[2]  = target_2;

    // inputs beyond the three ports count as zero
    for (genvar gi = 0; gi < INPUT_COUNT; gi++)
    begin : g_feat
        if (gi < 3)
        begin : g_port
            assign feat_in[gi] = feat_port[gi];
        end
        else
        begin : g_zero
            assign feat_in[gi] = '0;
        end
    end

    for (genvar go = 0; go < OUTPUT_COUNT; go++)
    begin : g_tgt
        if (go < 3)
        begin : g_port
            assign tgt_in[go] = tgt_port[go];
        end
        else
        begin : g_zero
            assign tgt_in[go] = '0;
        end
    end

    for (genvar gk = 0; gk < 3; gk++)
    begin : g_outs
        if (gk < OUTPUT_COUNT)
        begin : g_live
            assign outs_w[gk] = outv_reg[gk];
        end
        else
        begin : g_zero
            assign outs_w[gk] = '0;
        end
    end

    // one index serves every small array
    logic [IDX_W-1:0]  arr_idx;
    logic [IN_IW-1:0]  in_i;
    logic [HID_IW-1:0] hid_i;
    logic [OUT_IW-1:0] out_i;

    assign arr_idx = (cmd.op == DP_MUL) ? cmd.tidx : cmd.nidx;
    assign in_i    = arr_idx[IN_IW-1:0];
    assign hid_i   = arr_idx[HID_IW-1:0];
    assign out_i   = arr_idx[OUT_IW-1:0];

    // shared multiplier
    logic signed [OPB_W-1:0]  opnd;
    logic signed [MULA_W-1:0] mula;
    logic signed [PROD_W-1:0] prod_c;

    always_comb
    begin
        case (cmd.opd)
            OPD_FEAT: opnd = OPB_W'(feat_reg[in_i]);
            OPD_ONE:  opnd = OPB_W'(Q_ONE);
            OPD_HID:  opnd = OPB_W'($signed({1'b0, hid_reg[hid_i]}));
            OPD_DOUT: opnd = OPB_W'(dout_reg[out_i]);
            default:  opnd = '0;
        endcase
    end

    assign mula   = cmd.use_ld ? ld_reg : MULA_W'(rdata_reg);
    assign prod_c = PROD_W'(mula) * PROD_W'(opnd);

    // sigmoid lookup of the accumulator
    logic signed [ACC_W-13:0] z_full;
    logic signed [DATA_W-1:0] z_sat;
    logic [DATA_W-1:0]        z_off;
    logic [28:0]              idx_prod;
    logic [ACT_W-1:0]         sig_val;

    assign z_full = (ACC_W - 12)'(acc_reg >>> 12);

    always_comb
    begin
        if (z_full > (ACC_W - 12)'(32767))
        begin
            z_sat = 16'sh7fff;
        end
        else if (z_full < -(ACC_W - 12)'(32768))
        begin
            z_sat = 16'sh8000;
        end
        else
        begin
            z_sat = DATA_W'(z_full);
        end
    end

    assign z_off    = {~z_sat[DATA_W-1], z_sat[DATA_W-2:0]};
    assign idx_prod = 29'(z_off) * 29'(SIGMOID_TABLE_SIZE);
    assign sig_val  = SIG_TBL[idx_prod[16 +: TBL_AW]];

    // delta and update arithmetic
    logic signed [26:0]       dout_p;
    logic signed [31:0]       dhid_p;
    logic signed [DH_W-1:0]   delta_sel;
    logic signed [MULA_W-1:0] ld_c;
    logic signed [29:0]       step_c;
    logic signed [29:0]       neww_c;
    logic signed [DATA_W-1:0] neww_sat;

    assign dout_p = 27'(diff_reg) * 27'($signed({1'b0, drv_reg}));
    assign dhid_p = 32'(gq_reg) * 32'($signed({1'b0, drv_reg}));
    assign delta_sel = cmd.layer ? DH_W'(dout_reg[out_i]) : dhid_reg[hid_i];
    assign ld_c   = MULA_W'($signed({1'b0, lr})) * MULA_W'(delta_sel);
    assign step_c = 30'(prod_reg >>> 24);
    assign neww_c = 30'(rdata_reg) - step_c;

    always_comb
    begin
        if (neww_c > 30'sd32767)
        begin
            neww_sat = 16'sh7fff;
        end
        else if (neww_c < -30'sd32768)
        begin
            neww_sat = 16'sh8000;
        end
        else
        begin
            neww_sat = DATA_W'(neww_c);
        end
    end

    // weight memory, one port
    logic                     mem_we;
    logic signed [DATA_W-1:0] mem_wdata;
    logic [MEM_AW-1:0]        mem_addr;

    assign mem_we    = (cmd.op == DP_WRITE) || (cmd.op == DP_UPD);
    assign mem_wdata = (cmd.op == DP_WRITE) ? wv_reg : neww_sat;
    assign mem_addr  = cmd.addr[MEM_AW-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (cmd.op == DP_READ)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            feat_reg <= feat_in;
            tgt_reg  <= tgt_in;
            wv_reg   <= weight_value;
        end
        case (cmd.op)
            DP_MUL:
            begin
                prod_reg <= prod_c;
            end
            DP_ACC:
            begin
                acc_reg <= cmd.first ? ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);
            end
            DP_ACT:
            begin
                if (cmd.layer)
                begin
                    outv_reg[out_i] <= sig_val;
                end
                else
                begin
                    hid_reg[hid_i] <= sig_val;
                end
            end
            DP_DER_O:
            begin
                diff_reg <= $signed({2'b00, outv_reg[out_i]}) - $signed({2'b00, tgt_reg[out_i]});
                drv_reg  <= deriv(outv_reg[out_i]);
            end
            DP_DEL_O:
            begin
                dout_reg[out_i] <= DATA_W'(dout_p >>> 12);
            end
            DP_DER_H:
            begin
                gq_reg  <= DH_W'(acc_reg >>> 12);
                drv_reg <= deriv(hid_reg[hid_i]);
            end
            DP_DEL_H:
            begin
                dhid_reg[hid_i] <= DH_W'(dhid_p >>> 12);
            end
            DP_LD:
            begin
                ld_reg <= ld_c;
            end
            DP_PUB:
            begin
                out_0 <= (cmd.pub == PUB_OUT) ? outs_w[0] : '0;
                out_1 <= (cmd.pub == PUB_OUT) ? outs_w[1] : '0;
                out_2 <= (cmd.pub == PUB_OUT) ? outs_w[2] : '0;
                weight_readback <= (cmd.pub == PUB_RB) ? rdata_reg : '0;
            end
            default:
            begin
            end
        endcase
    end

endmodule

FILE: sv/mst_ctrl.sv
// ----------------------------------------------------------------------------
// mst_ctrl
// sequencer: runs weight writes and reads, walks forward pass, delta computation
// and weight update one memory word at a time and issues datapath commands
// ----------------------------------------------------------------------------
module mst_ctrl
    import mst_pkg::*;
#(
    parameter int INPUT_COUNT  = 3,
    parameter int HIDDEN_COUNT = 5,
    parameter int OUTPUT_COUNT = 3
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [1:0]  opcode,
    input  logic [5:0]  weight_index,
    output logic        result_valid,
    input  logic        result_ready,
    output dp_cmd_t     cmd,
    output logic        load
);

    localparam int B1_BASE = HIDDEN_COUNT * INPUT_COUNT;
    localparam int W2_BASE = B1_BASE + HIDDEN_COUNT;
    localparam int B2_BASE = W2_BASE + OUTPUT_COUNT * HIDDEN_COUNT;
    localparam int WEIGHT_COUNT = B2_BASE + OUTPUT_COUNT;

    typedef enum logic [4:0] {
        S_IDLE,
        S_WRITE,
        S_RD_ADDR,
        S_F_RD,
        S_F_MUL,
        S_F_ACC,
        S_F_ACT,
        S_O_DER,
        S_O_DEL,
        S_H_RD,
        S_H_MUL,
        S_H_ACC,
        S_H_DER,
        S_H_DEL,
        S_U_LD,
        S_U_RD,
        S_U_MUL,
        S_U_WR,
        S_DONE
    } state_t;

    state_t           state_reg, state_next;
    opcode_t          op_reg, op_next;
    logic [5:0]       idx_reg, idx_next;
    logic             layer_reg, layer_next;
    logic [IDX_W-1:0] neu_reg, neu_next;
    logic [IDX_W-1:0] term_reg, term_next;
    logic             result_valid_reg, result_valid_next;

    int   fanin;
    int   last_neu;
    int   addr_i;
    logic idx_ok;
    logic at_bias;
    logic at_last_neu;
    logic accept;
    logic publish;

    assign fanin       = layer_reg ? HIDDEN_COUNT : INPUT_COUNT;
    assign last_neu    = layer_reg ? OUTPUT_COUNT - 1 : HIDDEN_COUNT - 1;
    assign at_bias     = (int'(term_reg) == fanin);
    assign at_last_neu = (int'(neu_reg) == last_neu);
    assign idx_ok      = (int'(idx_reg) < WEIGHT_COUNT);
    assign item_ready  = (state_reg == S_IDLE);
    assign accept      = item_valid && item_ready;
    assign load        = accept;
    assign publish     = (state_reg == S_DONE) && (!result_valid_reg || result_ready);
    assign result_valid = result_valid_reg;

    // memory address of the current term
    always_comb
    begin
        if (state_reg == S_H_RD)
        begin
            addr_i = W2_BASE + int'(term_reg) * HIDDEN_COUNT + int'(neu_reg);
        end
        else if (state_reg == S_WRITE || state_reg == S_RD_ADDR)
        begin
            addr_i = int'(idx_reg);
        end
        else if (layer_reg)
        begin
            addr_i = at_bias ? B2_BASE + int'(neu_reg)
                             : W2_BASE + int'(neu_reg) * HIDDEN_COUNT + int'(term_reg);
        end
        else
        begin
            addr_i = at_bias ? B1_BASE + int'(neu_reg)
                             : int'(neu_reg) * INPUT_COUNT + int'(term_reg);
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.addr   = ADDR_W'(addr_i);
        cmd.nidx   = neu_reg;
        cmd.tidx   = term_reg;
        cmd.layer  = layer_reg;
        cmd.first  = (term_reg == '0);
        cmd.opd    = at_bias ? OPD_ONE : (layer_reg ? OPD_HID : OPD_FEAT);
        cmd.op     = DP_NOP;
        cmd.pub    = PUB_ZERO;
        cmd.use_ld = 1'b0;
        case (state_reg)
            S_WRITE:   cmd.op = DP_WRITE;
            S_RD_ADDR: cmd.op = DP_READ;
            S_F_RD:    cmd.op = DP_READ;
            S_F_MUL:   cmd.op = DP_MUL;
            S_F_ACC:   cmd.op = DP_ACC;
            S_F_ACT:   cmd.op = DP_ACT;
            S_O_DER:   cmd.op = DP_DER_O;
            S_O_DEL:   cmd.op = DP_DEL_O;
            S_H_RD:    cmd.op = DP_READ;
            S_H_MUL:
            begin
                cmd.op  = DP_MUL;
                cmd.opd = OPD_DOUT;
            end
            S_H_ACC:   cmd.op = DP_ACC;
            S_H_DER:   cmd.op = DP_DER_H;
            S_H_DEL:   cmd.op = DP_DEL_H;
            S_U_LD:    cmd.op = DP_LD;
            S_U_RD:    cmd.op = DP_READ;
            S_U_MUL:
            begin
                cmd.op     = DP_MUL;
                cmd.use_ld = 1'b1;
            end
            S_U_WR:    cmd.op = DP_UPD;
            S_DONE:
            begin
                cmd.op = publish ? DP_PUB : DP_NOP;
                if (op_reg == OPC_FORWARD || op_reg == OPC_TRAIN)
                begin
                    cmd.pub = PUB_OUT;
                end
                else if (op_reg == OPC_READ && idx_ok)
                begin
                    cmd.pub = PUB_RB;
                end
                else
                begin
                    cmd.pub = PUB_ZERO;
                end
            end
            default:   cmd.op = DP_NOP;
        endcase
    end

    always_comb
    begin
        state_next        = state_reg;
        op_next           = op_reg;
        idx_next          = idx_reg;
        layer_next        = layer_reg;
        neu_next          = neu_reg;
        term_next         = term_reg;
        result_valid_next = result_valid_reg;
        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = opcode_t'(opcode);
                    idx_next   = weight_index;
                    layer_next = 1'b0;
                    neu_next   = '0;
                    term_next  = '0;
                    case (opcode_t'(opcode))
                        OPC_WRITE:
                            state_next = (int'(weight_index) < WEIGHT_COUNT) ? S_WRITE : S_DONE;
                        OPC_READ:
                            state_next = (int'(weight_index) < WEIGHT_COUNT) ? S_RD_ADDR : S_DONE;
                        default:
                            state_next = S_F_RD;
                    endcase
                end
            end
            S_WRITE:   state_next = S_DONE;
            S_RD_ADDR: state_next = S_DONE;
            S_F_RD:    state_next = S_F_MUL;
            S_F_MUL:   state_next = S_F_ACC;
            S_F_ACC:
            begin
                if (at_bias)
                begin
                    state_next = S_F_ACT;
                end
                else
                begin
                    term_next  = term_reg + 1'b1;
                    state_next = S_F_RD;
                end
            end
            S_F_ACT:
            begin
                term_next = '0;
                if (!at_last_neu)
                begin
                    neu_next   = neu_reg + 1'b1;
                    state_next = S_F_RD;
                end
                else if (!layer_reg)
                begin
                    neu_next   = '0;
                    layer_next = 1'b1;
                    state_next = S_F_RD;
                end
                else if (op_reg == OPC_TRAIN)
                begin
                    neu_next   = '0;
                    state_next = S_O_DER;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_O_DER:   state_next = S_O_DEL;
            S_O_DEL:
            begin
                if (int'(neu_reg) == OUTPUT_COUNT - 1)
                begin
                    neu_next   = '0;
                    term_next  = '0;
                    state_next = S_H_RD;
                end
                else
                begin
                    neu_next   = neu_reg + 1'b1;
                    state_next = S_O_DER;
                end
            end
            S_H_RD:    state_next = S_H_MUL;
            S_H_MUL:   state_next = S_H_ACC;
            S_H_ACC:
            begin
                if (int'(term_reg) == OUTPUT_COUNT - 1)
                begin
                    state_next = S_H_DER;
                end
                else
                begin
                    term_next  = term_reg + 1'b1;
                    state_next = S_H_RD;
                end
            end
            S_H_DER:   state_next = S_H_DEL;
            S_H_DEL:
            begin
                term_next = '0;
                if (int'(neu_reg) == HIDDEN_COUNT - 1)
                begin
                    neu_next   = '0;
                    layer_next = 1'b1;
                    state_next = S_U_LD;
                end
                else
                begin
                    neu_next   = neu_reg + 1'b1;
                    state_next = S_H_RD;
                end
            end
            S_U_LD:
            begin
                term_next  = '0;
                state_next = S_U_RD;
            end
            S_U_RD:    state_next = S_U_MUL;
            S_U_MUL:   state_next = S_U_WR;
            S_U_WR:
            begin
                if (!at_bias)
                begin
                    term_next  = term_reg + 1'b1;
                    state_next = S_U_RD;
                end
                else if (!at_last_neu)
                begin
                    neu_next   = neu_reg + 1'b1;
                    state_next = S_U_LD;
                end
                else if (layer_reg)
                begin
                    neu_next   = '0;
                    layer_next = 1'b0;
                    state_next = S_U_LD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (publish)
                begin
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            op_reg           <= OPC_WRITE;
            idx_reg          <= '0;
            layer_reg        <= 1'b0;
            neu_reg          <= '0;
            term_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            op_reg           <= op_next;
            idx_reg          <= idx_next;
            layer_reg        <= layer_next;
            neu_reg          <= neu_next;
            term_reg         <= term_next;
            result_valid_reg <= result_valid_next;
        end
    end

endmodule

FILE: sv/mst_checker.sv
// ----------------------------------------------------------------------------
// mst_checker
// port-level checks of the perceptron trainer, bound to the top level
// ----------------------------------------------------------------------------
module mst_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_ready,
    input logic [1:0]  opcode,
    input logic [15:0] feature_0,
    input logic [15:0] feature_1,
    input logic [15:0] feature_2,
    input logic [12:0] target_0,
    input logic [12:0] target_1,
    input logic [12:0] target_2,
    input logic [5:0]  weight_index,
    input logic [15:0] weight_value,
    input logic        result_valid,
    input logic        result_ready,
    input logic [12:0] out_0,
    input logic [12:0] out_1,
    input logic [12:0] out_2,
    input logic [15:0] weight_readback,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    // a pending result is not withdrawn
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result withdrawn before transfer");

    // one item at a time: no second transfer right after one
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item taken while busy");

    // a result appears only after work, never in the cycle after a transfer
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && !result_valid |=> !result_valid)
        else $error("result without work");

    // register port never stalls and reads back only the rate bits
    a_reg_port: assert property (@(posedge clk) disable iff (!rst_n)
        pready && prdata[31:13] == 19'd0)
        else $error("register port misbehaves");

endmodule

bind mlp_sigmoid_sgd_trainer_core mst_checker u_mst_checker (.*);

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking testbench of the 3-5-3 sigmoid perceptron trainer: a queue
// fed driver, a randomly stalling result monitor and a bit-exact predictor
// of the q4.12 forward pass and sgd update, run over several learning rates
// and idling phases
// ----------------------------------------------------------------------------
module tb;
    import mst_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_IN   = 3;
    localparam int N_HID  = 5;
    localparam int N_OUT  = 3;
    localparam int N_SIG  = 256;
    localparam int B1_OFS = N_HID * N_IN;
    localparam int W2_OFS = B1_OFS + N_HID;
    localparam int B2_OFS = W2_OFS + N_OUT * N_HID;
    localparam int N_WGT  = B2_OFS + N_OUT;
    localparam logic [2:0] LR_ADDR = 3'd4 * REG_LEARNING_RATE;
    localparam int DRAIN_CYCLES = 400;          // beyond the longest train latency

    typedef struct packed {
        opcode_t                 op;
        logic signed [DATA_W-1:0] f0;
        logic signed [DATA_W-1:0] f1;
        logic signed [DATA_W-1:0] f2;
        logic [ACT_W-1:0]        t0;
        logic [ACT_W-1:0]        t1;
        logic [ACT_W-1:0]        t2;
        logic [5:0]              widx;
        logic signed [DATA_W-1:0] wval;
    } mlp_item_t;

    typedef struct packed {
        logic [ACT_W-1:0]        y0;
        logic [ACT_W-1:0]        y1;
        logic [ACT_W-1:0]        y2;
        logic signed [DATA_W-1:0] rb;
    } mlp_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_ready;
    logic [1:0] opcode = '0;
    logic signed [DATA_W-1:0] feature_0 = '0, feature_1 = '0, feature_2 = '0;
    logic [ACT_W-1:0] target_0 = '0, target_1 = '0, target_2 = '0;
    logic [5:0] weight_index = '0;
    logic signed [DATA_W-1:0] weight_value = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    logic [ACT_W-1:0] out_0, out_1, out_2;
    logic signed [DATA_W-1:0] weight_readback;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    mlp_item_t   pending_items[$];
    mlp_result_t expected_results[$];
    mlp_item_t   driven_item;

    // predictor state
    longint model_weights[N_WGT];
    longint model_lr;
    longint sig_lut[N_SIG];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatch_count = 0;

    mlp_sigmoid_sgd_trainer_core dut (.*);

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic void build_sigmoid_lut();
        longint d;
        longint unsigned n, a, t, t2, t3, e, num, den;
        for (int k = 0; k < N_SIG; k++)
        begin
            d = 32 * k + 16 - 16 * N_SIG;
            n = (d < 0) ? -d : d;
            a = (n << 30) / (2 * N_SIG);
            t = a >> 8;
            t2 = (t * t) >> 30;
            t3 = (t2 * t) >> 30;
            e = (64'd1 << 30) - t + t2 / 2 - t3 / 6;
            for (int i = 0; i < 8; i++)
                e = (e * e) >> 30;
            den = (64'd1 << 30) + e;
            num = (d < 0) ? e : (64'd1 << 30);
            sig_lut[k] = (4096 * num + den / 2) / den;
        end
    endfunction

    function automatic longint clamp16(longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic longint sigmoid_of(longint acc);
        longint z, k;
        z = clamp16(acc >>> 12);
        k = ((z + 32768) * N_SIG) / 65536;
        if (k >= N_SIG)
            k = N_SIG - 1;
        return sig_lut[k];
    endfunction

    function automatic longint slope_of(longint y);
        return (y * (4096 - y)) >>> 12;
    endfunction

    function automatic void nudge_weight(int k, longint step);
        model_weights[k] = clamp16(model_weights[k] - step);
    endfunction

    // applies one item to the predictor state and returns its result
    function automatic mlp_result_t predict_result(mlp_item_t it);
        mlp_result_t r;
        longint x[N_IN], tg[N_OUT], hid[N_HID], y[N_OUT];
        longint d_out[N_OUT], d_hid[N_HID];
        longint acc, g;
        r = '0;
        x[0] = it.f0; x[1] = it.f1; x[2] = it.f2;
        tg[0] = it.t0; tg[1] = it.t1; tg[2] = it.t2;
        case (it.op)
            OPC_WRITE:
                if (it.widx < N_WGT)
                    model_weights[it.widx] = it.wval;
            OPC_READ:
                if (it.widx < N_WGT)
                    r.rb = DATA_W'(model_weights[it.widx]);
            default:
            begin
                for (int h = 0; h < N_HID; h++)
                begin
                    acc = model_weights[B1_OFS + h] * 4096;
                    for (int i = 0; i < N_IN; i++)
                        acc += model_weights[h * N_IN + i] * x[i];
                    hid[h] = sigmoid_of(acc);
                end
                for (int o = 0; o < N_OUT; o++)
                begin
                    acc = model_weights[B2_OFS + o] * 4096;
                    for (int h = 0; h < N_HID; h++)
                        acc += model_weights[W2_OFS + o * N_HID + h] * hid[h];
                    y[o] = sigmoid_of(acc);
                end
                if (it.op == OPC_TRAIN)
                begin
                    for (int o = 0; o < N_OUT; o++)
                        d_out[o] = ((y[o] - tg[o]) * slope_of(y[o])) >>> 12;
                    // hidden deltas use the second-layer weights before the update
                    for (int h = 0; h < N_HID; h++)
                    begin
                        g = 0;
                        for (int o = 0; o < N_OUT; o++)
                            g += model_weights[W2_OFS + o * N_HID + h] * d_out[o];
                        d_hid[h] = ((g >>> 12) * slope_of(hid[h])) >>> 12;
                    end
                    for (int o = 0; o < N_OUT; o++)
                    begin
                        for (int h = 0; h < N_HID; h++)
                            nudge_weight(W2_OFS + o * N_HID + h,
                                         (model_lr * d_out[o] * hid[h]) >>> 24);
                        nudge_weight(B2_OFS + o, (model_lr * d_out[o]) >>> 12);
                    end
                    for (int h = 0; h < N_HID; h++)
                    begin
                        for (int i = 0; i < N_IN; i++)
                            nudge_weight(h * N_IN + i, (model_lr * d_hid[h] * x[i]) >>> 24);
                        nudge_weight(B1_OFS + h, (model_lr * d_hid[h]) >>> 12);
                    end
                end
                r.y0 = y[0][ACT_W-1:0];
                r.y1 = y[1][ACT_W-1:0];
                r.y2 = y[2][ACT_W-1:0];
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // driver: item transfers, prediction taken at the accepting edge
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            if (item_valid && item_ready)
                expected_results.push_back(predict_result(driven_item));
            // slot is free when nothing is held or the held item just went
            if (!item_valid || item_ready)
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    driven_item   = pending_items.pop_front();
                    opcode        <= driven_item.op;
                    feature_0     <= driven_item.f0;
                    feature_1     <= driven_item.f1;
                    feature_2     <= driven_item.f2;
                    target_0      <= driven_item.t0;
                    target_1      <= driven_item.t1;
                    target_2      <= driven_item.t2;
                    weight_index  <= driven_item.widx;
                    weight_value  <= driven_item.wval;
                    item_valid    <= 1'b1;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: random back-pressure, field by field comparison
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        mlp_result_t want;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result transfer: out %0d %0d %0d rb %0d",
                                 out_0, out_1, out_2, weight_readback);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_0 !== want.y0 || out_1 !== want.y1 || out_2 !== want.y2
                        || weight_readback !== want.rb)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected out %0d %0d %0d rb %0d, got %0d %0d %0d rb %0d",
                                     want.y0, want.y1, want.y2, want.rb,
                                     out_0, out_1, out_2, weight_readback);
                    end
                end
            end
            result_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    function automatic mlp_item_t make_item(opcode_t op, int widx, int wval,
                                            int f0, int f1, int f2,
                                            int t0, int t1, int t2);
        mlp_item_t it;
        it.op = op;
        it.widx = 6'(widx);
        it.wval = DATA_W'(wval);
        it.f0 = DATA_W'(f0); it.f1 = DATA_W'(f1); it.f2 = DATA_W'(f2);
        it.t0 = ACT_W'(t0); it.t1 = ACT_W'(t1); it.t2 = ACT_W'(t2);
        return it;
    endfunction

    // features mostly near the working range, sometimes anywhere
    function automatic int pick_feature();
        if ($urandom_range(9) < 2)
            return $signed(16'($urandom()));
        return $signed(16'($urandom_range(16383))) - 8192;
    endfunction

    function automatic int pick_weight();
        if ($urandom_range(9) == 0)
            return $signed(16'($urandom()));
        return int'($urandom_range(8191)) - 4096;
    endfunction

    function automatic int pick_target();
        if ($urandom_range(9) == 0)
            return $urandom_range(8191);     // up to almost two, used as given
        return $urandom_range(4096);
    endfunction

    function automatic mlp_item_t random_item();
        int roll, idx;
        opcode_t op;
        roll = $urandom_range(99);
        if (roll < 15)
            op = OPC_WRITE;
        else if (roll < 30)
            op = OPC_READ;
        else if (roll < 60)
            op = OPC_FORWARD;
        else
            op = OPC_TRAIN;
        idx = ($urandom_range(9) == 0) ? $urandom_range(63, N_WGT) : $urandom_range(N_WGT - 1);
        return make_item(op, idx, pick_weight(), pick_feature(), pick_feature(),
                         pick_feature(), pick_target(), pick_target(), pick_target());
    endfunction

    task automatic write_learning_rate(int unsigned value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LR_ADDR;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        model_lr = value & 32'h1FFF;
    endtask

    // sampled away from the rising edge so the driver's updates have settled
    task automatic wait_until_idle();
        @(negedge clk);
        while (pending_items.size() > 0 || item_valid || expected_results.size() > 0)
            @(negedge clk);
    endtask

    initial
    begin
        int lr_values[5];
        for (int k = 0; k < N_WGT; k++)
            model_weights[k] = 0;
        model_lr = LR_RESET;
        build_sigmoid_lut();
        lr_values = '{410, 0, 4096, 8191, 0};
        lr_values[4] = $urandom_range(1, 2047);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // load every weight before anything reads the store
        for (int k = 0; k < N_WGT; k++)
            pending_items.push_back(make_item(OPC_WRITE, k, int'($urandom_range(4095)) - 2048,
                                              0, 0, 0, 0, 0, 0));
        // directed: index edges, out of range write and read
        pending_items.push_back(make_item(OPC_READ, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OPC_READ, N_WGT - 1, 0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OPC_READ, N_WGT, 0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OPC_READ, 63, 0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OPC_WRITE, 40, 1234, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OPC_READ, 40, 0, 0, 0, 0, 0, 0, 0));
        // forward and train at feature and target extremes, reset learning rate
        pending_items.push_back(make_item(OPC_FORWARD, 0, 0, 32767, -32768, 0, 0, 0, 0));
        pending_items.push_back(make_item(OPC_FORWARD, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OPC_TRAIN, 0, 0, 32767, -32768, 4096, 0, 4096, 8191));
        pending_items.push_back(make_item(OPC_TRAIN, 0, 0, -32768, 32767, -1, 4096, 0, 0));
        // extreme stored weights, saturating sums and updates
        pending_items.push_back(make_item(OPC_WRITE, 5, 32767, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OPC_READ, 5, 0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OPC_WRITE, B2_OFS, -32768, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OPC_READ, B2_OFS, 0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OPC_WRITE, W2_OFS, 32767, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OPC_FORWARD, 0, 0, 32767, 32767, 32767, 0, 0, 0));
        pending_items.push_back(make_item(OPC_TRAIN, 0, 0, 32767, 32767, 32767, 0, 8191, 4096));
        pending_items.push_back(make_item(OPC_READ, 5, 0, 0, 0, 0, 0, 0, 0));
        wait_until_idle();

        // random phases, each with its own learning rate and one of four idling mixes
        for (int ph = 0; ph < 5; ph++)
        begin
            write_learning_rate(lr_values[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
                1: begin send_idle_pct = 57; recv_idle_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_idle_pct = 57; end
                default: begin send_idle_pct = 18; recv_idle_pct = 18; end
            endcase
            for (int n = 0; n < 100; n++)
                pending_items.push_back(random_item());
            wait_until_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // run limit far beyond the slowest correct run
    initial
    begin
        #20ms;
        $display("status: fail");
        $finish;
    end

endmodule
